### rtl/anbf_pkg.sv
// ----------------------------------------------------------------------------
// anbf_pkg - shared types and constants of the Annex B NAL filter
// Request layouts of both channels, the internal command word passed from
// the classifier to the expander, and the NAL type codes.
// ----------------------------------------------------------------------------
package anbf_pkg;

	localparam logic [7:0]  TYPE_MASK  = 8'h1f;
	localparam logic [31:0] START_CODE = 32'h0000_0001;
	localparam logic [2:0]  HDR_LEN    = 3'd4;

	localparam logic [4:0] NAL_IDR = 5'd5;
	localparam logic [4:0] NAL_SPS = 5'd7;
	localparam logic [4:0] NAL_PPS = 5'd8;

	typedef enum logic [1:0] {
		PH_SEEK = 2'd0,
		PH_CODE = 2'd1,
		PH_UNIT = 2'd2
	} phase_t;

	typedef struct packed {
		logic [7:0] in_byte;
		logic       unit_end;
	} in_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       byte_valid;
		logic       buffer_done;
		logic       key_frame;
	} out_t;

	// One classified input byte: optional start code, zero run, the byte
	// itself and an optional end marker, emitted in that order.
	typedef struct packed {
		logic       hdr;
		logic [2:0] zeros;
		logic       byte_en;
		logic [7:0] data;
		logic       done;
		logic       key;
	} cmd_t;

endpackage

### rtl/anbf_front.sv
// ----------------------------------------------------------------------------
// anbf_front - start code classifier
// Tracks held zeros and unit phase, turns each accepted byte that emits or ends a unit into a command.
// ----------------------------------------------------------------------------
module anbf_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                strip,
	input  logic                raw_valid,
	output logic                raw_stall,
	input  anbf_pkg::in_t       raw_req,
	input  logic                full,
	output logic                push,
	output anbf_pkg::cmd_t      cmd
);

	anbf_pkg::phase_t phase_q, phase_n, phase_cur;
	logic [1:0] held_q, held_n, held_step;
	logic       drop_q, drop_n, key_q, key_n;
	logic       accept, last, held3, is_zero, is_code, has_b, units, opens;
	logic       emit, drop_after, key_after;
	logic [2:0] zcnt;
	logic [7:0] first_byte;
	logic [4:0] nal_type;

	assign raw_stall = full;
	assign accept    = raw_valid & ~full;
	assign last      = raw_req.unit_end;
	assign held3     = (held_q == 2'd3);
	assign held_step = held3 ? 2'd3 : held_q + 2'd1;
	assign is_zero   = (raw_req.in_byte == 8'h00);
	assign is_code   = (raw_req.in_byte == 8'h01) && (held_q >= 2'd2);
	assign has_b     = ~is_zero & ~is_code;

	// zeros released as unit bytes by this request
	always_comb begin
		if (is_zero) begin
			zcnt = {2'b00, held3} + (last ? {1'b0, held_step} : 3'd0);
		end else if (is_code) begin
			zcnt = 3'd0;
		end else begin
			zcnt = {1'b0, held_q};
		end
	end

	always_comb begin
		unique case (phase_q)
			anbf_pkg::PH_CODE: phase_cur = anbf_pkg::PH_CODE;
			anbf_pkg::PH_UNIT: phase_cur = anbf_pkg::PH_UNIT;
			default:           phase_cur = anbf_pkg::PH_SEEK;
		endcase
	end

	assign units      = (zcnt != 3'd0) | has_b;
	assign opens      = (phase_cur == anbf_pkg::PH_CODE) & units;
	assign first_byte = (zcnt != 3'd0) ? 8'h00 : raw_req.in_byte;
	assign nal_type   = first_byte[4:0] & anbf_pkg::TYPE_MASK[4:0];

	assign drop_after = opens ? (strip && (nal_type == anbf_pkg::NAL_SPS ||
	                                       nal_type == anbf_pkg::NAL_PPS))
	                          : drop_q;
	assign key_after  = key_q | (opens && (nal_type == anbf_pkg::NAL_IDR ||
	                                       nal_type == anbf_pkg::NAL_SPS ||
	                                       nal_type == anbf_pkg::NAL_PPS));
	assign emit       = units & (phase_cur != anbf_pkg::PH_SEEK) & ~drop_after;

	// command outputs
	always_comb begin
		cmd.hdr     = emit & opens;
		cmd.zeros   = emit ? zcnt : 3'd0;
		cmd.byte_en = emit & has_b;
		cmd.data    = raw_req.in_byte;
		cmd.done    = last;
		cmd.key     = key_after;
		push        = accept & (emit | last);
	end

	// next state
	always_comb begin
		phase_n = phase_cur;
		held_n  = held_q;
		drop_n  = drop_q;
		key_n   = key_q;
		if (accept) begin
			if (last) begin
				phase_n = anbf_pkg::PH_SEEK;
				held_n  = 2'd0;
				drop_n  = 1'b0;
				key_n   = 1'b0;
			end else begin
				held_n = is_zero ? held_step : 2'd0;
				key_n  = key_after;
				if (is_code) begin
					phase_n = anbf_pkg::PH_CODE;
					drop_n  = 1'b0;
				end else if (opens) begin
					phase_n = anbf_pkg::PH_UNIT;
					drop_n  = drop_after;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= anbf_pkg::PH_SEEK;
			held_q  <= 2'd0;
			drop_q  <= 1'b0;
			key_q   <= 1'b0;
		end else begin
			phase_q <= phase_n;
			held_q  <= held_n;
			drop_q  <= drop_n;
			key_q   <= key_n;
		end
	end

endmodule

### rtl/anbf_queue.sv
// ----------------------------------------------------------------------------
// anbf_queue - command queue
// Small register queue between the classifier and the expander.
// ----------------------------------------------------------------------------
module anbf_queue #(
	parameter int DEPTH = 4
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  anbf_pkg::cmd_t wr_cmd,
	input  logic           pop,
	output anbf_pkg::cmd_t rd_cmd,
	output logic           full,
	output logic           empty
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
	localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

	anbf_pkg::cmd_t    slot_q [DEPTH];
	logic [PW-1:0]     wr_ptr_q, rd_ptr_q;
	logic [CW-1:0]     count_q;
	logic              do_push, do_pop;

	assign full    = (count_q == FULL_CNT);
	assign empty   = (count_q == '0);
	assign do_push = push & ~full;
	assign do_pop  = pop & ~empty;
	assign rd_cmd  = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= wr_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

### rtl/anbf_back.sv
// ----------------------------------------------------------------------------
// anbf_back - command expander
// Plays out one command as output requests, one per cycle while the output
// is not stalled, into the output register.
// ----------------------------------------------------------------------------
module anbf_back (
	input  logic           clk,
	input  logic           arst_n,
	input  anbf_pkg::cmd_t rd_cmd,
	input  logic           empty,
	output logic           pop,
	output logic           nal_valid,
	input  logic           nal_stall,
	output anbf_pkg::out_t nal_req
);

	logic [2:0]     hdr_cnt_q, zero_cnt_q, hdr_cnt_n, zero_cnt_n;
	logic           byte_en_q, done_q, key_q, byte_en_n, done_n;
	logic [7:0]     data_q;
	logic           busy, out_free, adv, last_elem;
	logic [2:0]     hdr_sub;
	anbf_pkg::out_t elem;
	logic           nal_valid_q;
	anbf_pkg::out_t nal_q;

	assign busy     = (hdr_cnt_q != 3'd0) | (zero_cnt_q != 3'd0) | byte_en_q | done_q;
	assign out_free = ~nal_valid_q | ~nal_stall;
	assign adv      = busy & out_free;
	assign hdr_sub  = hdr_cnt_q - 3'd1;

	// pick the next element and what remains after it
	always_comb begin
		hdr_cnt_n  = hdr_cnt_q;
		zero_cnt_n = zero_cnt_q;
		byte_en_n  = byte_en_q;
		done_n     = done_q;
		elem       = '0;
		if (hdr_cnt_q != 3'd0) begin
			elem.out_byte   = anbf_pkg::START_CODE[{hdr_sub[1:0], 3'b000} +: 8];
			elem.byte_valid = 1'b1;
			hdr_cnt_n       = hdr_sub;
		end else if (zero_cnt_q != 3'd0) begin
			elem.byte_valid = 1'b1;
			zero_cnt_n      = zero_cnt_q - 3'd1;
		end else if (byte_en_q) begin
			elem.out_byte   = data_q;
			elem.byte_valid = 1'b1;
			byte_en_n       = 1'b0;
		end else begin
			elem.buffer_done = 1'b1;
			elem.key_frame   = key_q;
			done_n           = 1'b0;
		end
	end

	assign last_elem = (hdr_cnt_n == 3'd0) & (zero_cnt_n == 3'd0) & ~byte_en_n & ~done_n;
	assign pop       = ~empty & (~busy | (adv & last_elem));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hdr_cnt_q  <= 3'd0;
			zero_cnt_q <= 3'd0;
			byte_en_q  <= 1'b0;
			done_q     <= 1'b0;
		end else if (pop) begin
			hdr_cnt_q  <= rd_cmd.hdr ? anbf_pkg::HDR_LEN : 3'd0;
			zero_cnt_q <= rd_cmd.zeros;
			byte_en_q  <= rd_cmd.byte_en;
			done_q     <= rd_cmd.done;
		end else if (adv) begin
			hdr_cnt_q  <= hdr_cnt_n;
			zero_cnt_q <= zero_cnt_n;
			byte_en_q  <= byte_en_n;
			done_q     <= done_n;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			data_q <= rd_cmd.data;
			key_q  <= rd_cmd.key;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			nal_valid_q <= 1'b0;
		end else if (out_free) begin
			nal_valid_q <= busy;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free) begin
			nal_q <= elem;
		end
	end

	assign nal_valid = nal_valid_q;
	assign nal_req   = nal_q;

endmodule

### rtl/annexb_nal_filter.sv
// ----------------------------------------------------------------------------
// annexb_nal_filter - Annex B start code parser and rewriter
// The first output request of a byte goes from the classifier into the
// queue, then through the expander into the output register.
// Throughput: one input byte per cycle while the queue has room; output runs
// at one request per cycle while not stalled, and the expander may expand one
// byte into a start code, released zeros, the byte and an end marker.
// Reset: all parse state and the queue clear; strip_param_sets resets to 1.
// ----------------------------------------------------------------------------
module annexb_nal_filter #(
	parameter int QUEUE_DEPTH = 4
) (
	input  logic           clk,
	input  logic           arst_n,
	// raw byte channel
	input  logic           raw_valid,
	output logic           raw_stall,
	input  anbf_pkg::in_t  raw_req,
	// rewritten stream channel
	output logic           nal_valid,
	input  logic           nal_stall,
	output anbf_pkg::out_t nal_req,
	// configuration write channel: strip_param_sets
	input  logic           cfg_valid,
	output logic           cfg_ready,
	input  logic           cfg_data
);

	logic           strip_q;
	logic           push, pop, full, empty;
	anbf_pkg::cmd_t wr_cmd, rd_cmd;

	// Take configuration writes at any time; the user must issue them only while idle, which the block does not enforce.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			strip_q <= 1'b1;
		end else if (cfg_valid && cfg_ready) begin
			strip_q <= cfg_data;
		end
	end

	// Front: hold back zero runs, spot start codes, classify each unit's
	// first byte and decide whether the unit goes out or is dropped.
	anbf_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.strip     (strip_q),
		.raw_valid (raw_valid),
		.raw_stall (raw_stall),
		.raw_req   (raw_req),
		.full      (full),
		.push      (push),
		.cmd       (wr_cmd)
	);

	// Queue: absorb output bursts so the front keeps taking bytes.
	anbf_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wr_cmd (wr_cmd),
		.pop    (pop),
		.rd_cmd (rd_cmd),
		.full   (full),
		.empty  (empty)
	);

	// Back: expand each command into output requests, one per cycle while the output is not stalled.
	anbf_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.rd_cmd    (rd_cmd),
		.empty     (empty),
		.pop       (pop),
		.nal_valid (nal_valid),
		.nal_stall (nal_stall),
		.nal_req   (nal_req)
	);

endmodule
